@@ rtl/core/fse_pkg.sv @@
package fse_pkg;

    localparam int WEIGHT_BITS  = 14;
    localparam int SUPPORT_BITS = 16;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DAT_BITS = 32;
    localparam int NUM_SENSORS  = 8;
    localparam int SENSOR_BITS  = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PRESSURE = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PRESSURE = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUTER_WEIGHT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INNER_WEIGHT = 8'd3;

    // bit i set: sensor i sits on an outer edge
    localparam logic [NUM_SENSORS-1:0] OUTER_MASK = 8'b1010_0101;

    localparam logic [WEIGHT_BITS-1:0] OUTER_RESET = 14'd8192;
    localparam logic [WEIGHT_BITS-1:0] INNER_RESET = 14'd4096;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_LOAD  = 7'b000_0010,
        S_DIV   = 7'b000_0100,
        S_ACC   = 7'b000_1000,
        S_FINAL = 7'b001_0000,
        S_FDIV  = 7'b010_0000,
        S_OUT   = 7'b100_0000
    } t_state;

endpackage

@@ rtl/core/foot_support_estimator.sv @@
// channel   | direction | payload
// ----------+-----------+-----------------------------------------------
// s_axis    | in        | eight pressure samples, PRESSURE_BITS each
// m_axis    | out       | tdata: support (Q2.13), tuser: switched
// cfg       | in        | register index and write data, taken only when idle
//
// NUM_W is the width of the shared serial divider (34 at default
// parameters); the divider produces one quotient bit per cycle: eight
// sensor fractions, then the final weighted sum over total; a zero total
// skips the last division
// reset is synchronous active low; peaks load the reset min_pressure
// a new frame is taken while a finished result still waits on m_axis
module foot_support_estimator import fse_pkg::*; #(
    parameter int PRESSURE_BITS = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // fields from bit 0 up: left_front_left, left_front_right, left_back_left,
    // left_back_right, right_front_left, right_front_right, right_back_left,
    // right_back_right
    input  logic [NUM_SENSORS*PRESSURE_BITS-1:0] s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // fields: support
    output logic [SUPPORT_BITS-1:0]            m_axis_tdata,
    // fields: switched
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]            i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0]            i_cfg_data
);
    localparam int PB    = PRESSURE_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int FW    = FB + 1;              // fraction reaches 1.0
    localparam int PW    = FW + WEIGHT_BITS;    // one weighted term
    localparam int AW    = PW + 4;              // signed sum of eight terms
    localparam int MW    = AW - 1;              // magnitude of the sum
    localparam int TW    = FW + 3;              // total of fractions
    localparam int NUM_W = (PB + FB > MW) ? PB + FB : MW;
    localparam int DEN_W = (PB > TW) ? PB : TW;
    localparam int FRAME_W = NUM_SENSORS * PB;

    t_state r_state;

    logic [PB-1:0]          r_max_p;
    logic [WEIGHT_BITS-1:0] r_outer_w;
    logic [WEIGHT_BITS-1:0] r_inner_w;
    logic [PB-1:0]          r_peak [NUM_SENSORS];

    logic [FRAME_W-1:0]     r_frame;
    logic [SENSOR_BITS-1:0] r_idx;
    logic                   r_zero;
    logic [FW-1:0]          r_frac;
    logic signed [AW-1:0]   r_wsum;
    logic [TW-1:0]          r_total;
    logic                   r_neg;
    logic [SUPPORT_BITS-1:0] r_mag;
    logic signed [SUPPORT_BITS-1:0] r_last;

    logic [SUPPORT_BITS-1:0] r_out_data;
    logic                   r_out_sw;
    logic                   r_out_valid;

    // per sensor and final result datapath
    logic [PB-1:0]          n_sample;
    logic [PB-1:0]          n_clip;
    logic [PB-1:0]          n_pk;
    logic [WEIGHT_BITS-1:0] n_w;
    logic [PW-1:0]          n_prod;
    logic [MW-1:0]          n_abs;
    logic signed [SUPPORT_BITS-1:0] n_sup;
    logic                   n_sw;

    logic                   div_start;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quo;

    logic                   s_xfer;
    logic                   m_xfer;
    logic                   cfg_xfer;

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign m_xfer   = r_out_valid && m_axis_tready;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;

    // registers change only between frames; a register write and a frame
    // transfer at the same edge apply the write first
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);

    always_comb begin
        n_sample = r_frame[PB-1:0];
        n_clip   = (n_sample > r_max_p) ? r_max_p : n_sample;
        n_pk     = (n_clip > r_peak[r_idx]) ? n_clip : r_peak[r_idx];
        n_w      = OUTER_MASK[r_idx] ? r_outer_w : r_inner_w;
        n_prod   = PW'(r_frac) * PW'(n_w);
        n_abs    = r_wsum[AW-1] ? MW'(-r_wsum) : MW'(r_wsum);
        n_sup    = r_neg ? -$signed(r_mag) : $signed(r_mag);
        n_sw     = (r_last < 0 && n_sup > 0) || (r_last > 0 && n_sup < 0);
    end

    // shared divider: sample over peak, then sum over total
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        if (r_state == S_LOAD) begin
            div_start = 1'b1;
            div_num   = NUM_W'({n_clip, {FB{1'b0}}});
            div_den   = DEN_W'(n_pk);
        end else if (r_state == S_FINAL && r_total != '0) begin
            div_start = 1'b1;
            div_num   = NUM_W'(n_abs);
            div_den   = DEN_W'(r_total);
        end
    end

    fse_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration and peaks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_p   <= PB'(20480);
            r_outer_w <= OUTER_RESET;
            r_inner_w <= INNER_RESET;
            for (int i = 0; i < NUM_SENSORS; i++) r_peak[i] <= PB'(410);
        end else begin
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    REG_MAX_PRESSURE: r_max_p <= i_cfg_data[PB-1:0];
                    REG_MIN_PRESSURE: begin
                        for (int i = 0; i < NUM_SENSORS; i++)
                            r_peak[i] <= i_cfg_data[PB-1:0];
                    end
                    REG_OUTER_WEIGHT: r_outer_w <= i_cfg_data[WEIGHT_BITS-1:0];
                    REG_INNER_WEIGHT: r_inner_w <= i_cfg_data[WEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_LOAD) r_peak[r_idx] <= n_pk;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_xfer) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_idx   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD:  r_state <= S_DIV;
                S_DIV:   if (div_done) r_state <= S_ACC;
                S_ACC: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (r_idx == SENSOR_BITS'(NUM_SENSORS - 1)) ? S_FINAL : S_LOAD;
                end
                S_FINAL: r_state <= (r_total == '0) ? S_OUT : S_FDIV;
                S_FDIV:  if (div_done) r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_last      <= n_sup;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_frame <= s_axis_tdata;
                r_wsum  <= '0;
                r_total <= '0;
            end
            S_LOAD: r_zero <= (n_pk == '0);
            S_DIV:  r_frac <= r_zero ? '0 : div_quo[FW-1:0];
            S_ACC: begin
                r_frame <= r_frame >> PB;
                r_total <= r_total + TW'(r_frac);
                if (r_idx < SENSOR_BITS'(NUM_SENSORS / 2))
                    r_wsum <= r_wsum + $signed({{(AW-PW){1'b0}}, n_prod});
                else
                    r_wsum <= r_wsum - $signed({{(AW-PW){1'b0}}, n_prod});
            end
            S_FINAL: begin
                r_neg <= r_wsum[AW-1];
                r_mag <= '0;
            end
            S_FDIV: r_mag <= div_quo[SUPPORT_BITS-1:0];
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= n_sup;
                    r_out_sw   <= n_sw;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sw;
    assign m_axis_tvalid = r_out_valid;
endmodule

@@ rtl/core/fse_divider.sv @@
// restoring divider, one quotient bit per cycle
module fse_divider import fse_pkg::*; #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_trial;
    logic             n_fit;

    always_comb begin
        n_trial = {r_rem, r_num[NUM_W-1]};
        n_fit   = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits DEN_W bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_fit ? DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

@@ sim/foot_support_estimator_tb.sv @@
`timescale 1ns / 1ps

module foot_support_estimator_tb;
    import fse_pkg::*;

    localparam int PBITS     = 16;
    localparam int FRAME_W   = NUM_SENSORS * PBITS;
    localparam int FRAME_LAT = 400;

    // expected output of one frame
    typedef struct {
        logic [SUPPORT_BITS-1:0] support;
        logic                    switched;
    } t_support_exp;

    // scoreboard: mirrors the register file, the per-sensor peaks and the
    // previous support, and holds the supports still owed by the block
    class support_tracker;
        longint unsigned max_p, min_p, outer_w, inner_w;
        longint unsigned peak [NUM_SENSORS];
        int              last_support;
        t_support_exp    pending [$];

        function new();
            max_p        = 20480;
            min_p        = 410;
            outer_w      = OUTER_RESET;
            inner_w      = INNER_RESET;
            last_support = 0;
            foreach (peak[i]) peak[i] = 410;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] val);
            case (idx)
                REG_MAX_PRESSURE: max_p = val[PBITS-1:0];
                REG_MIN_PRESSURE: begin
                    min_p = val[PBITS-1:0];
                    foreach (peak[i]) peak[i] = min_p;
                end
                REG_OUTER_WEIGHT: outer_w = val[WEIGHT_BITS-1:0];
                REG_INNER_WEIGHT: inner_w = val[WEIGHT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // accepted frame: clip, track peaks, weight the fractions, divide
        function void note_frame(logic [FRAME_W-1:0] d);
            longint unsigned total, p, frac, w, mag;
            longint          wsum;
            int              sup;
            logic            sw;
            t_support_exp    e;
            total = 0;
            wsum  = 0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                p = d[i*PBITS +: PBITS];
                if (p > max_p) p = max_p;
                if (p > peak[i]) peak[i] = p;
                frac = (peak[i] != 0) ? (p << 16) / peak[i] : 0;
                total += frac;
                w = OUTER_MASK[i] ? outer_w : inner_w;
                if (i < 4) wsum += longint'(frac * w);
                else       wsum -= longint'(frac * w);
            end
            sup = 0;
            sw  = 1'b0;
            if (total != 0) begin
                mag = longint'(wsum < 0 ? -wsum : wsum);
                mag = mag / total;
                sup = int'(mag);
                if (wsum < 0) sup = -sup;
                sw = (longint'(last_support) * longint'(sup)) < 0;
            end
            last_support = sup;
            e.support    = sup[SUPPORT_BITS-1:0];
            e.switched   = sw;
            pending.push_back(e);
        endfunction

        // returns an empty string when the result matches the oldest entry
        function string check_result(logic [SUPPORT_BITS-1:0] sup, logic sw);
            t_support_exp e;
            if (pending.size() == 0)
                return $sformatf("unexpected result support=%h switched=%b", sup, sw);
            e = pending.pop_front();
            if (sup !== e.support || sw !== e.switched)
                return $sformatf("support=%h switched=%b, expected %h %b",
                                 sup, sw, e.support, e.switched);
            return "";
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic [FRAME_W-1:0]      s_axis_tdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SUPPORT_BITS-1:0] m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DAT_BITS-1:0] i_cfg_data = '0;

    support_tracker tracker = new();
    int  mismatches = 0;
    int  frames_in = 0;        // accepted input transfers
    int  cfg_writes = 0;       // accepted config transfers
    int  send_idle_pct = 0;    // chance in percent of a sender gap cycle
    int  recv_idle_pct = 0;    // chance in percent of a receiver stall cycle
    bit  hold_request = 1'b0;  // asks the receiver for one long hold-off

    always #1 i_clk = ~i_clk;

    foot_support_estimator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // monitor: every transfer is seen at the rising edge
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.write_reg(i_cfg_index, i_cfg_data);
                cfg_writes <= cfg_writes + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.note_frame(s_axis_tdata);
                frames_in <= frames_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                msg = tracker.check_result(m_axis_tdata, m_axis_tuser);
                if (msg != "") report_mismatch(msg);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_left    = 3000;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_frame(logic [FRAME_W-1:0] d);
        int seen;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        seen = frames_in;
        do @(negedge i_clk); while (frames_in == seen);
    endtask

    // register writes happen only with the block idle
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DAT_BITS-1:0] val);
        int seen;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        seen = cfg_writes;
        do @(negedge i_clk); while (cfg_writes == seen);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(negedge i_clk);
        repeat (FRAME_LAT) @(negedge i_clk);
    endtask

    task automatic set_regs(int mx, int mn, int ow, int iw);
        drain();
        write_reg(REG_MAX_PRESSURE, mx);
        write_reg(REG_MIN_PRESSURE, mn);
        write_reg(REG_OUTER_WEIGHT, ow);
        write_reg(REG_INNER_WEIGHT, iw);
    endtask

    function automatic logic [FRAME_W-1:0] fill(logic [PBITS-1:0] v, logic [7:0] sel);
        logic [FRAME_W-1:0] d;
        d = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
            if (sel[i]) d[i*PBITS +: PBITS] = v;
        return d;
    endfunction

    // random frame: mostly plausible loads around the clip level
    function automatic logic [FRAME_W-1:0] random_frame();
        logic [FRAME_W-1:0] d;
        int                 mode, lim;
        mode = $urandom_range(9);
        lim  = (tracker.max_p == 0) ? 1 : int'(tracker.max_p);
        for (int i = 0; i < NUM_SENSORS; i++) begin
            case (mode)
                0: d[i*PBITS +: PBITS] = PBITS'($urandom);
                1: d[i*PBITS +: PBITS] = '0;
                2: d[i*PBITS +: PBITS] = 16'hFFFF;
                3: d[i*PBITS +: PBITS] = (i < 4) ? PBITS'($urandom_range(lim)) : '0;
                4: d[i*PBITS +: PBITS] = (i >= 4) ? PBITS'($urandom_range(lim)) : '0;
                5: d[i*PBITS +: PBITS] = ($urandom_range(3) == 0) ? '0 :
                                         PBITS'($urandom_range(lim));
                default: d[i*PBITS +: PBITS] = PBITS'($urandom_range(
                             lim + lim / 4 > 65535 ? 65535 : lim + lim / 4));
            endcase
        end
        return d;
    endfunction

    initial begin
        int settings [8][4] = '{
            '{20480, 410, 8192, 4096},
            '{65535, 1, 16383, 16383},
            '{1, 1, 0, 0},
            '{65535, 65535, 16383, 0},
            '{4096, 200, 0, 16383},
            '{0, 0, 0, 0},
            '{0, 0, 0, 0},
            '{0, 0, 0, 0}
        };
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames at reset settings
        send_idle_pct = 20;
        recv_idle_pct = 20;
        send_frame(fill(16'h0000, 8'hFF));
        send_frame(fill(16'hFFFF, 8'hFF));
        for (int i = 0; i < NUM_SENSORS; i++) send_frame(fill(16'd5000, 8'h01 << i));
        send_frame(fill(16'd3000, 8'h0F));   // left foot only
        send_frame(fill(16'd3000, 8'hF0));   // right only: sign flips
        send_frame(fill(16'd3000, 8'h0F));   // and back
        send_frame(fill(16'd0, 8'hFF));      // zero total clears history
        send_frame(fill(16'd1, 8'hF0));

        // clip level of zero forces a zero support
        set_regs(0, 410, 8192, 4096);
        send_frame(fill(16'd9000, 8'h0F));
        send_frame(fill(16'hFFFF, 8'hFF));
        // zero peak with zero samples: quotient discarded, fraction zero
        set_regs(65535, 0, 8192, 4096);
        send_frame({16'd0, 16'd0, 16'd0, 16'd7, 16'd0, 16'd0, 16'd0, 16'd0});
        send_frame(fill(16'd0, 8'hFF));
        // out-of-range register indexes are ignored
        drain();
        write_reg(8'd4, 32'hFFFF_FFFF);
        write_reg(8'd255, 32'h0);
        send_frame(fill(16'd1234, 8'h3C));

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 5) begin
                settings[ph][0] = $urandom_range(65535, 1);
                settings[ph][1] = $urandom_range(65535, 1);
                settings[ph][2] = $urandom_range(16383);
                settings[ph][3] = $urandom_range(16383);
            end
            set_regs(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
            if (ph < 3) begin
                send_idle_pct = 35;
                recv_idle_pct = 68;
            end else if (ph < 6) begin
                send_idle_pct = 68;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 6) hold_request = 1'b1;   // block backs up and stalls input
            for (int n = 0; n < 200; n++) send_frame(random_frame());
        end

        drain();
        while (tracker.pending.size() != 0) begin
            report_mismatch("result never arrived");
            void'(tracker.pending.pop_front());
        end
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
